>>> src/rau_pkg.sv
package rau_pkg;

  localparam int unsigned OW = 32;  // operand bits taken from each input word
  localparam int unsigned PW = 2 * OW;
  localparam int unsigned WW = 64;  // width of numerator and denominator paths
  localparam int unsigned CW = $clog2(WW);

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_NEG = 3'd4;
  localparam logic [2:0] FUNC_CMP = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd2;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       comb;
    logic       gcd_step;
    logic       div_start;
    logic       div_step;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic early;
    logic neg_op;
    logic skip_gcd;
    logic gcd_done;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

  // Magnitude of the low OW bits read as two's complement.
  function automatic logic [OW-1:0] mag_of(input logic [31:0] v);
    logic [OW-1:0] x;
    x = v[OW-1:0];
    return x[OW-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

>>> src/rau_ctrl.sv
module rau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rau_pkg::dp_stat_t  stat_i,
  output rau_pkg::dp_cmd_t   cmd_o
);

  rau_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rau_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rau_pkg::ST_CHECK;
      end
      rau_pkg::ST_CHECK: begin
        if (stat_i.early) state_d = rau_pkg::ST_OUT;
        else if (stat_i.neg_op) state_d = rau_pkg::ST_COMB;
        else state_d = rau_pkg::ST_MUL0;
      end
      rau_pkg::ST_MUL0: state_d = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1: state_d = rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2: state_d = rau_pkg::ST_COMB;
      rau_pkg::ST_COMB: state_d = rau_pkg::ST_GCD;
      rau_pkg::ST_GCD: begin
        if (stat_i.skip_gcd) state_d = rau_pkg::ST_OUT;
        else if (stat_i.gcd_done) state_d = rau_pkg::ST_DIV;
      end
      rau_pkg::ST_DIV: begin
        if (stat_i.div_last) state_d = rau_pkg::ST_OUT;
      end
      rau_pkg::ST_OUT: begin
        if (!stat_i.out_busy) state_d = rau_pkg::ST_IDLE;
      end
      default: state_d = rau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rau_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      rau_pkg::ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = 2'd0;
      end
      rau_pkg::ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = 2'd1;
      end
      rau_pkg::ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = 2'd2;
      end
      rau_pkg::ST_COMB: cmd_o.comb = 1'b1;
      rau_pkg::ST_GCD: begin
        cmd_o.gcd_step  = !stat_i.skip_gcd && !stat_i.gcd_done;
        cmd_o.div_start = !stat_i.skip_gcd && stat_i.gcd_done;
      end
      rau_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      rau_pkg::ST_OUT: cmd_o.out_load = !stat_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> src/rau_dpath.sv
module rau_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rau_pkg::dp_cmd_t    cmd_i,
  output rau_pkg::dp_stat_t   stat_o,
  input  logic [2:0]          func_i,
  input  logic [31:0]         a_num_i,
  input  logic [31:0]         a_den_i,
  input  logic [31:0]         b_num_i,
  input  logic [31:0]         b_den_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [63:0]         res_num_o,
  output logic [62:0]         res_den_o,
  output logic [1:0]          order_o,
  output logic [1:0]          status_o
);

  localparam int unsigned OW = rau_pkg::OW;
  localparam int unsigned WW = rau_pkg::WW;
  localparam int unsigned CW = rau_pkg::CW;

  logic [2:0]    func_q;
  logic [OW-1:0] an_q, ad_q, bn_q, bd_q;
  logic          sa_q, sb_q;
  logic [1:0]    stat_q;
  logic          bad_q;
  logic [WW-1:0] p_q [3];
  logic          neg_q;
  logic [WW-1:0] n_q, d_q;
  logic [1:0]    ord_q;
  logic [WW-1:0] gx_q, gy_q;
  logic [CW-1:0] gk_q;
  logic [WW-1:0] g_q, rn_q, rd_q, qn_q, qd_q;
  logic [CW-1:0] cnt_q;
  logic          ovalid_q;
  logic [63:0]   onum_q;
  logic [62:0]   oden_q;
  logic [1:0]    oord_q, ostat_q;

  logic [OW-1:0] an_m, ad_m, bn_m, bd_m;
  logic          an_s, ad_s, bn_s, bd_s;
  logic [1:0]    stat_d;

  assign an_m = rau_pkg::mag_of(a_num_i);
  assign ad_m = rau_pkg::mag_of(a_den_i);
  assign bn_m = rau_pkg::mag_of(b_num_i);
  assign bd_m = rau_pkg::mag_of(b_den_i);
  assign an_s = a_num_i[OW-1];
  assign ad_s = a_den_i[OW-1];
  assign bn_s = b_num_i[OW-1];
  assign bd_s = b_den_i[OW-1];

  always_comb begin
    stat_d = rau_pkg::STAT_OK;
    if (ad_m == '0 || (func_i != rau_pkg::FUNC_NEG && bd_m == '0)) begin
      stat_d = rau_pkg::STAT_ZERO_DEN;
    end else if (func_i == rau_pkg::FUNC_DIV && bn_m == '0) begin
      stat_d = rau_pkg::STAT_DIV_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      an_q   <= an_m;
      ad_q   <= ad_m;
      bn_q   <= bn_m;
      bd_q   <= bd_m;
      sa_q   <= an_s ^ ad_s;
      sb_q   <= bn_s ^ bd_s;
      bad_q  <= func_i > rau_pkg::FUNC_CMP;
      stat_q <= (func_i > rau_pkg::FUNC_CMP) ? rau_pkg::STAT_OK : stat_d;
    end
  end

  // One shared multiplier; the three products are taken one per cycle.
  logic [OW-1:0]           mul_a, mul_b;
  logic [rau_pkg::PW-1:0]  prod;

  always_comb begin
    mul_a = ad_q;
    mul_b = bd_q;
    case (cmd_i.mul_sel)
      2'd0: begin
        mul_a = an_q;
        mul_b = (func_q == rau_pkg::FUNC_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_a = ad_q;
        mul_b = bn_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q[cmd_i.mul_sel] <= WW'(prod);
    end
  end

  // Sign and magnitude combination of the products.
  logic          c_neg, bneg;
  logic [WW-1:0] c_n, c_d;
  logic [1:0]    c_ord;
  logic signed [WW-1:0] cx, cy;

  always_comb begin
    bneg  = sb_q ^ (func_q == rau_pkg::FUNC_SUB);
    c_neg = sa_q ^ sb_q;
    c_n   = p_q[0];
    c_d   = p_q[2];
    cx    = sa_q ? -$signed(p_q[0]) : $signed(p_q[0]);
    cy    = sb_q ? -$signed(p_q[1]) : $signed(p_q[1]);
    c_ord = (cx < cy) ? rau_pkg::ORD_LESS :
            ((cx == cy) ? rau_pkg::ORD_EQUAL : rau_pkg::ORD_GREATER);
    case (func_q)
      rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
        if (sa_q == bneg) begin
          c_n   = p_q[0] + p_q[1];
          c_neg = sa_q;
        end else if (p_q[0] >= p_q[1]) begin
          c_n   = p_q[0] - p_q[1];
          c_neg = sa_q;
        end else begin
          c_n   = p_q[1] - p_q[0];
          c_neg = bneg;
        end
      end
      rau_pkg::FUNC_DIV: begin
        c_n = p_q[0];
        c_d = p_q[1];
      end
      rau_pkg::FUNC_NEG: begin
        c_n   = WW'(an_q);
        c_d   = WW'(ad_q);
        c_neg = !sa_q;
      end
      default: begin
        c_n = p_q[0];
        c_d = p_q[2];
      end
    endcase
  end

  // Binary gcd, one step per cycle.
  logic [WW-1:0] gx_d, gy_d;
  logic [CW-1:0] gk_d;
  logic          gcd_done;

  assign gcd_done = (gx_q == '0) || (gy_q == '0);

  always_comb begin
    gx_d = gx_q;
    gy_d = gy_q;
    gk_d = gk_q;
    if (!gx_q[0] && !gy_q[0]) begin
      gx_d = gx_q >> 1;
      gy_d = gy_q >> 1;
      gk_d = gk_q + 1'b1;
    end else if (!gx_q[0]) begin
      gx_d = gx_q >> 1;
    end else if (!gy_q[0]) begin
      gy_d = gy_q >> 1;
    end else if (gx_q >= gy_q) begin
      gx_d = gx_q - gy_q;
    end else begin
      gy_d = gy_q - gx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comb) begin
      n_q   <= c_n;
      d_q   <= c_d;
      neg_q <= c_neg;
      ord_q <= c_ord;
      gx_q  <= c_n;
      gy_q  <= c_d;
      gk_q  <= '0;
    end else if (cmd_i.gcd_step) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
      gk_q <= gk_d;
    end
  end

  // Restoring division of numerator and denominator by the gcd side by side.
  logic [WW-1:0] rn_sh, rd_sh;
  assign rn_sh = {rn_q[WW-2:0], qn_q[WW-1]};
  assign rd_sh = {rd_q[WW-2:0], qd_q[WW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      g_q   <= (gx_q | gy_q) << gk_q;
      rn_q  <= '0;
      rd_q  <= '0;
      qn_q  <= n_q;
      qd_q  <= d_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
      if (rn_sh >= g_q) begin
        rn_q <= rn_sh - g_q;
        qn_q <= {qn_q[WW-2:0], 1'b1};
      end else begin
        rn_q <= rn_sh;
        qn_q <= {qn_q[WW-2:0], 1'b0};
      end
      if (rd_sh >= g_q) begin
        rd_q <= rd_sh - g_q;
        qd_q <= {qd_q[WW-2:0], 1'b1};
      end else begin
        rd_q <= rd_sh;
        qd_q <= {qd_q[WW-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  logic [63:0] onum_d;
  logic [62:0] oden_d;
  logic [1:0]  oord_d;

  // Errors and unknown codes leave every field but the status at zero.
  always_comb begin
    onum_d = '0;
    oden_d = '0;
    oord_d = rau_pkg::ORD_LESS;
    if (!bad_q && stat_q == rau_pkg::STAT_OK) begin
      if (func_q == rau_pkg::FUNC_CMP) begin
        oord_d = ord_q;
      end else if (n_q == '0) begin
        oden_d = 63'd1;
      end else begin
        onum_d = neg_q ? (64'd0 - qn_q) : qn_q;
        oden_d = qd_q[62:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      onum_q  <= onum_d;
      oden_q  <= oden_d;
      oord_q  <= oord_d;
      ostat_q <= stat_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign res_num_o   = onum_q;
  assign res_den_o   = oden_q;
  assign order_o     = oord_q;
  assign status_o    = ostat_q;

  assign stat_o.early    = bad_q || (stat_q != rau_pkg::STAT_OK);
  assign stat_o.neg_op   = func_q == rau_pkg::FUNC_NEG;
  assign stat_o.skip_gcd = (func_q == rau_pkg::FUNC_CMP) || (n_q == '0);
  assign stat_o.gcd_done = gcd_done;
  assign stat_o.div_last = cnt_q == CW'(WW - 1);
  assign stat_o.out_busy = ovalid_q && !out_ready_i;

endmodule

>>> src/rational_arithmetic_unit.sv
// Channel   Dir  tdata (low bit up)                                tuser
// s_axis    in   a_num[31:0] a_den[63:32] b_num[95:64] b_den[127:96]  func[2:0]
// m_axis    out  res_num[63:0] res_den[126:64] order[128:127]
//                status[130:129], zeros to 135                     -
//
// One item at a time. After the accepting transfer: a check state, three products
// on one shared multiplier (negate skips them), a combine state, the binary gcd loop
// (one step per cycle), the restoring divider and an output load.
// Errors and unknown codes go from the check state straight to the output load;
// compare and zero results skip the gcd loop and the divider. Reset clears the
// controller and the output valid flag. A result held in the output register stalls
// only the next item's final load.
module rational_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_axis_tuser_i,  // func
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o   // res_num, res_den, order, status, pad
);

  rau_pkg::dp_cmd_t  cmd;
  rau_pkg::dp_stat_t stat;
  logic [63:0] res_num;
  logic [62:0] res_den;
  logic [1:0]  order, status;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rau_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (s_axis_tuser_i),
    .a_num_i     (s_axis_tdata_i[31:0]),
    .a_den_i     (s_axis_tdata_i[63:32]),
    .b_num_i     (s_axis_tdata_i[95:64]),
    .b_den_i     (s_axis_tdata_i[127:96]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .res_num_o   (res_num),
    .res_den_o   (res_den),
    .order_o     (order),
    .status_o    (status)
  );

  assign m_axis_tdata_o = {5'd0, status, order, res_den, res_num};

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status != rau_pkg::STAT_OK |-> res_num == '0 && res_den == '0)
    else $error("error result carries a nonzero fraction");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_den == '0 |-> res_num == '0)
    else $error("nonzero numerator over zero denominator");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("new item accepted while one is in work");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> order != 2'd3)
    else $error("invalid compare outcome");

endmodule

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] a_num, a_den, b_num, b_den;
  } op_item_t;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  ord;
    logic [1:0]  stat;
  } frac_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic [2:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [135:0] m_axis_tdata_o;

  rational_arithmetic_unit dut (.*);

  op_item_t pending_ops[$];
  frac_res_t expected_fracs[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int n_results = 0;
  int n_errstat = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Lowest terms on magnitudes; a zero part collapses to 0/1 with positive sign.
  function automatic void lowest_terms(inout bit neg, inout logic [63:0] n,
                                       inout logic [63:0] d);
    logic [63:0] g;
    if (n == 0 || d == 0) begin
      neg = 0;
      n = 0;
      d = 1;
    end else begin
      g = gcd64(n, d);
      n = n / g;
      d = d / g;
    end
  endfunction

  function automatic frac_res_t rational_result(input op_item_t it);
    frac_res_t r;
    bit an_s, ad_s, bn_s, bd_s, a_s, b_s, bs, r_s;
    logic [63:0] an, ad, bn, bd, t1, t2, dm, rn, rd;
    logic signed [63:0] x, y;
    r = '{num: '0, den: '0, ord: rau_pkg::ORD_LESS, stat: rau_pkg::STAT_OK};
    an_s = it.a_num[31]; an = {32'd0, it.a_num[31] ? -it.a_num : it.a_num};
    ad_s = it.a_den[31]; ad = {32'd0, it.a_den[31] ? -it.a_den : it.a_den};
    bn_s = it.b_num[31]; bn = {32'd0, it.b_num[31] ? -it.b_num : it.b_num};
    bd_s = it.b_den[31]; bd = {32'd0, it.b_den[31] ? -it.b_den : it.b_den};
    if (it.func > rau_pkg::FUNC_CMP) return r;
    if (ad == 0 || (it.func != rau_pkg::FUNC_NEG && bd == 0)) begin
      r.stat = rau_pkg::STAT_ZERO_DEN;
      return r;
    end
    a_s = an_s ^ ad_s;
    b_s = bn_s ^ bd_s;
    lowest_terms(a_s, an, ad);
    lowest_terms(b_s, bn, bd);
    case (it.func)
      rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
        bs = (it.func == rau_pkg::FUNC_SUB) ? !b_s : b_s;
        t1 = an * bd;
        t2 = ad * bn;
        rd = ad * bd;
        if (a_s == bs) begin r_s = a_s; rn = t1 + t2; end
        else if (t1 >= t2) begin r_s = a_s; rn = t1 - t2; end
        else begin r_s = bs; rn = t2 - t1; end
      end
      rau_pkg::FUNC_MUL: begin r_s = a_s ^ b_s; rn = an * bn; rd = ad * bd; end
      rau_pkg::FUNC_DIV: begin
        if (bn == 0) begin
          r.stat = rau_pkg::STAT_DIV_ZERO;
          return r;
        end
        r_s = a_s ^ b_s; rn = an * bd; rd = ad * bn;
      end
      rau_pkg::FUNC_NEG: begin r_s = !a_s; rn = an; rd = ad; end
      default: begin
        x = an * bd;
        y = ad * bn;
        if (a_s) x = -x;
        if (b_s) y = -y;
        r.ord = (x < y) ? rau_pkg::ORD_LESS :
                ((x == y) ? rau_pkg::ORD_EQUAL : rau_pkg::ORD_GREATER);
        return r;
      end
    endcase
    lowest_terms(r_s, rn, rd);
    r.num = r_s ? -rn : rn;
    r.den = rd[62:0];
    return r;
  endfunction

  // Driver: moves the head of the pending queue onto the slave side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (s_axis_tvalid_i) expected_fracs.push_back(rational_result(
            '{s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[63:32],
              s_axis_tdata_i[95:64], s_axis_tdata_i[127:96]}));
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          op_item_t it;
          it = pending_ops.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= it.func;
          s_axis_tdata_i <= {it.b_den, it.b_num, it.a_den, it.a_num};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      frac_res_t e;
      if (expected_fracs.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        e = expected_fracs.pop_front();
        n_results++;
        if (e.stat != rau_pkg::STAT_OK) n_errstat++;
        if (e.num !== m_axis_tdata_o[63:0] || e.den !== m_axis_tdata_o[126:64] ||
            e.ord !== m_axis_tdata_o[128:127] || e.stat !== m_axis_tdata_o[130:129] ||
            m_axis_tdata_o[135:131] !== 5'd0) begin
          $display("%0t: mismatch expected num=%0d den=%0d ord=%0d stat=%0d", $time,
                   $signed(e.num), e.den, e.ord, e.stat);
          $display("%0t:           actual   num=%0d den=%0d ord=%0d stat=%0d pad=%b",
                   $time, $signed(m_axis_tdata_o[63:0]), m_axis_tdata_o[126:64],
                   m_axis_tdata_o[128:127], m_axis_tdata_o[130:129],
                   m_axis_tdata_o[135:131]);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0001 + $urandom_range(2);
      1: return 32'h7fff_ffff - $urandom_range(2);
      2: return $urandom_range(8) - 4;
      3: return ($urandom_range(1) ? -1 : 1) * (($urandom_range(60) + 1) * 60);
      4: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic [2:0] f, input logic [31:0] an, input logic [31:0] ad,
                        input logic [31:0] bn, input logic [31:0] bd);
    pending_ops.push_back('{f, an, ad, bn, bd});
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || s_axis_tvalid_i || expected_fracs.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    op_item_t it;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_op(rau_pkg::FUNC_ADD, 1, 2, 1, 3);
    add_op(rau_pkg::FUNC_SUB, 1, 3, 1, 2);
    add_op(rau_pkg::FUNC_MUL, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 32'h7fff_ffff);
    add_op(rau_pkg::FUNC_DIV, 3, -4, -6, 8);
    add_op(rau_pkg::FUNC_NEG, 5, -10, 0, 0);
    add_op(rau_pkg::FUNC_CMP, 1, 3, 2, 6);
    add_op(rau_pkg::FUNC_CMP, -1, 3, 1, 3);
    add_op(rau_pkg::FUNC_CMP, 2, 3, 1, 3);
    add_op(rau_pkg::FUNC_ADD, 0, 7, 0, -9);
    add_op(rau_pkg::FUNC_ADD, 1, 0, 1, 2);
    add_op(rau_pkg::FUNC_MUL, 1, 2, 1, 0);
    add_op(rau_pkg::FUNC_NEG, 1, 0, 1, 1);
    add_op(rau_pkg::FUNC_DIV, 1, 2, 0, 5);
    add_op(rau_pkg::FUNC_DIV, 1, 0, 0, 5);
    add_op(3'd6, 1, 2, 3, 4);
    add_op(3'd7, -1, -1, -1, -1);
    add_op(rau_pkg::FUNC_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1);
    add_op(rau_pkg::FUNC_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(rau_pkg::FUNC_DIV, 32'h8000_0000, 1, 1, 32'h8000_0000);
    add_op(rau_pkg::FUNC_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    add_op(rau_pkg::FUNC_NEG, 32'h8000_0000, 3, 0, 0);
    add_op(rau_pkg::FUNC_CMP, 32'h7fff_ffff, 1, 32'h8000_0000, 1);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 29 : 0;
      recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 29 : 0;
      for (int i = 0; i < 382; i++) begin
        it.func = ($urandom_range(30) == 0) ? 3'(6 + $urandom_range(1))
                                            : 3'($urandom_range(5));
        it.a_num = rand_operand();
        it.a_den = ($urandom_range(40) == 0) ? 32'd0 : rand_operand();
        it.b_num = rand_operand();
        it.b_den = ($urandom_range(40) == 0) ? 32'd0 : rand_operand();
        if ($urandom_range(1) == 0) it.b_num = 0;
        if ($urandom_range(9) > 1 && it.b_num == 0) it.b_num = rand_operand();
        pending_ops.push_back(it);
      end
      drain();
    end
    $display("Ran %0d rational operations across four idle/stall phases,", n_results);
    $display("%0d of them with an error status.", n_errstat);
    if (errors == 0 && expected_fracs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
